@@ rtl/patu_pkg.sv @@
// Shared types, codes and helper functions for the paged address translation unit.
// Depends on nothing; every other file of the block but patu_cfg_if uses it.
package patu_pkg;

    localparam int unsigned ADDR_W   = 18;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned PHYS_W   = 19;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned DEPTH    = 16;

    localparam logic [15:0]       IO_PAGE_LIMIT = 16'o167777;
    localparam logic [PHYS_W-1:0] IO_PAGE_OFS   = 19'o600000;
    localparam logic [17:0]       BANK_KDESC_A  = 18'o772300;
    localparam logic [17:0]       BANK_KBASE_A  = 18'o772340;
    localparam logic [17:0]       BANK_UDESC_A  = 18'o777600;
    localparam logic [17:0]       BANK_UBASE_A  = 18'o777640;

    typedef enum logic [1:0] {
        REQ_XLATE_RD = 2'd0,
        REQ_XLATE_WR = 2'd1,
        REQ_REG_RD   = 2'd2,
        REQ_REG_WR   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        FLT_NONE   = 3'd0,
        FLT_BUS    = 3'd1,
        FLT_RDONLY = 3'd2,
        FLT_NOACC  = 3'd3,
        FLT_LEN    = 3'd4
    } t_fault;

    typedef enum logic [2:0] {
        BANK_NONE,
        BANK_KDESC,
        BANK_KBASE,
        BANK_UDESC,
        BANK_UBASE
    } t_bank;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic [PHYS_W-1:0] phys_addr;
        logic [WORD_W-1:0] read_data;
        t_fault            fault;
        logic [WORD_W-1:0] status_word;
        logic              abort_ld;
        logic [WORD_W-1:1] abort_val;
        logic              desc_we;
        logic [WORD_W-1:0] desc_wdata;
        logic              base_we;
        logic [WORD_W-1:0] base_wdata;
    } t_exec_out;

    // Bits 4..0 of a register address are ignored, so only bits 17..5 pick the bank.
    function automatic t_bank decode_bank(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] bank;
        bank = {addr[ADDR_W-1:5], 5'b0};
        if (bank == BANK_KDESC_A)      return BANK_KDESC;
        else if (bank == BANK_KBASE_A) return BANK_KBASE;
        else if (bank == BANK_UDESC_A) return BANK_UDESC;
        else if (bank == BANK_UBASE_A) return BANK_UBASE;
        else                           return BANK_NONE;
    endfunction

    function automatic logic [IDX_W-1:0] entry_index(
        input t_req              req,
        input logic [ADDR_W-1:0] addr,
        input logic              user
    );
        t_bank bank;
        bank = decode_bank(addr);
        if (req == REQ_XLATE_RD || req == REQ_XLATE_WR)
            return {user, addr[15:13]};
        else
            return {(bank == BANK_UDESC || bank == BANK_UBASE), addr[3:1]};
    endfunction

endpackage

@@ rtl/patu_req_if.sv @@
// Request channel of the translation unit: valid/ready plus the request fields.
// Depends on patu_pkg for the field widths.
interface patu_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [patu_pkg::ADDR_W-1:0]   address;
    logic                          user_mode;
    logic [patu_pkg::WORD_W-1:0]   write_data;

    modport source (output valid, req_type, address, user_mode, write_data, input ready);
    modport sink   (input valid, req_type, address, user_mode, write_data, output ready);
endinterface

@@ rtl/patu_rsp_if.sv @@
// Response channel of the translation unit: valid/ready plus the response fields.
// Depends on patu_pkg for the field widths.
interface patu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [patu_pkg::PHYS_W-1:0]   phys_addr;
    logic [patu_pkg::WORD_W-1:0]   read_data;
    logic [2:0]                    fault;
    logic [patu_pkg::WORD_W-1:0]   status_word;

    modport source (output valid, phys_addr, read_data, fault, status_word, input ready);
    modport sink   (input valid, phys_addr, read_data, fault, status_word, output ready);
endinterface

@@ rtl/patu_cfg_if.sv @@
// Configuration write channel: valid/ready and the relocation enable bit.
// No dependencies.
interface patu_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/patu_page_ram.sv @@
// Sixteen-word synchronous memory with registered read and reset-cleared
// valid bits, so entries never written read as zero. Depends on patu_pkg.
module patu_page_ram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [patu_pkg::IDX_W-1:0]   i_waddr,
    input  logic [patu_pkg::WORD_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [patu_pkg::IDX_W-1:0]   i_raddr,
    output logic [patu_pkg::WORD_W-1:0]  o_rdata
);
    import patu_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata & {WORD_W{r_rd_valid}};
endmodule

@@ rtl/patu_exec.sv @@
// Execute logic: translation checks, abort status and register access for one request,
// working on the words read from the two page memories. Depends on patu_pkg.
module patu_exec (
    input  logic [1:0]                   i_req_type,
    input  logic [patu_pkg::ADDR_W-1:0]  i_address,
    input  logic                         i_user_mode,
    input  logic [patu_pkg::WORD_W-1:0]  i_write_data,
    input  logic [patu_pkg::WORD_W-1:0]  i_pdr,
    input  logic [patu_pkg::WORD_W-1:0]  i_pbr,
    input  logic                         i_enable,
    input  logic [patu_pkg::WORD_W-1:1]  i_abort,
    output patu_pkg::t_exec_out          o_res
);
    import patu_pkg::*;

    t_req        req;
    t_bank       bank;
    logic [15:0] va;
    logic [6:0]  block;
    logic [6:0]  plen;
    logic        over;
    logic        is_wr;
    logic [12:0] base_sum;
    logic [15:0] abort_word;

    always_comb begin
        req      = t_req'(i_req_type);
        bank     = decode_bank(i_address);
        va       = i_address[15:0];
        block    = va[12:6];
        plen     = i_pdr[14:8];
        is_wr    = (req == REQ_XLATE_WR);
        over     = i_pdr[3] ? (block < plen) : (block > plen);
        base_sum = {1'b0, i_pbr[11:0]} + {6'b0, block};

        o_res            = '0;
        o_res.fault      = FLT_NONE;
        o_res.desc_wdata = i_pdr | 16'h0040;
        o_res.base_wdata = i_write_data;
        abort_word       = 16'h0001 | {12'b0, va[15:13], 1'b0} |
                           (i_user_mode ? 16'h0060 : 16'h0000);

        case (req)
            REQ_XLATE_RD, REQ_XLATE_WR: begin
                if (!i_enable) begin
                    // Only the top 4 KB of the address space moves up to the I/O page.
                    if (va > IO_PAGE_LIMIT)
                        o_res.phys_addr = {3'b0, va} + IO_PAGE_OFS;
                    else
                        o_res.phys_addr = {3'b0, va};
                end else if (is_wr && i_pdr[2:1] != 2'b11) begin
                    o_res.fault    = FLT_RDONLY;
                    o_res.abort_ld = 1'b1;
                    abort_word[13] = 1'b1;
                end else if (!i_pdr[1]) begin
                    o_res.fault    = FLT_NOACC;
                    o_res.abort_ld = 1'b1;
                    abort_word[15] = 1'b1;
                end else if (over) begin
                    o_res.fault    = FLT_LEN;
                    o_res.abort_ld = 1'b1;
                    abort_word[14] = 1'b1;
                end else begin
                    o_res.desc_we   = is_wr;
                    o_res.phys_addr = {base_sum, va[5:0]};
                end
            end
            REQ_REG_RD, REQ_REG_WR: begin
                o_res.desc_wdata = i_write_data;
                case (bank)
                    BANK_KDESC, BANK_UDESC: begin
                        o_res.read_data = (req == REQ_REG_RD) ? i_pdr : '0;
                        o_res.desc_we   = (req == REQ_REG_WR);
                    end
                    BANK_KBASE, BANK_UBASE: begin
                        o_res.read_data = (req == REQ_REG_RD) ? i_pbr : '0;
                        o_res.base_we   = (req == REQ_REG_WR);
                    end
                    default: begin
                        o_res.fault = FLT_BUS;
                    end
                endcase
            end
            default: begin
                o_res.fault = FLT_NONE;
            end
        endcase

        o_res.abort_val   = o_res.abort_ld ? abort_word[15:1] : i_abort;
        o_res.status_word = {o_res.abort_val, i_enable};
    end
endmodule

@@ rtl/paged_address_translation_unit_top.sv @@
// Paged address translation unit: top level with request, response and config channels.
// An accepted request first reads both page memories, then execute registers its response.
// A new request is taken only once the last has left execute, since the page memory read
// precedes the read-modify-write of the descriptor word; a waiting response stalls execute.
// Reset (synchronous, active low) clears relocation enable, abort status and memory valid
// bits, so all descriptor and base words read as zero. Depends on patu_pkg and the interfaces.
module paged_address_translation_unit_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    patu_req_if.sink   i_req,
    patu_rsp_if.source o_rsp,
    patu_cfg_if.sink   i_cfg
);
    import patu_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              req_acc;
    logic              out_free;
    logic              exec_ld;

    logic [1:0]        r_req_type;
    logic [ADDR_W-1:0] r_address;
    logic              r_user_mode;
    logic [WORD_W-1:0] r_write_data;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  in_idx;

    logic              r_mmu_enable;
    logic [WORD_W-1:1] r_abort;

    logic              r_out_valid;
    logic [PHYS_W-1:0] r_out_phys;
    logic [WORD_W-1:0] r_out_rdata;
    logic [2:0]        r_out_fault;
    logic [WORD_W-1:0] r_out_status;

    logic [WORD_W-1:0] pdr;
    logic [WORD_W-1:0] pbr;
    t_exec_out         ex;

    assign req_acc  = i_req.valid & i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign in_idx   = entry_index(t_req'(i_req.req_type), i_req.address, i_req.user_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        exec_ld     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid)
                    n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    exec_ld = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req_type   <= i_req.req_type;
            r_address    <= i_req.address;
            r_user_mode  <= i_req.user_mode;
            r_write_data <= i_req.write_data;
            r_idx        <= in_idx;
        end
        if (exec_ld) begin
            r_out_phys   <= ex.phys_addr;
            r_out_rdata  <= ex.read_data;
            r_out_fault  <= ex.fault;
            r_out_status <= ex.status_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mmu_enable <= 1'b0;
            r_abort      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                r_mmu_enable <= i_cfg.data;
            if (exec_ld)
                r_abort <= ex.abort_val;
            if (exec_ld)
                r_out_valid <= 1'b1;
            else if (o_rsp.ready)
                r_out_valid <= 1'b0;
        end
    end

    patu_page_ram u_desc_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (exec_ld && ex.desc_we),
        .i_waddr (r_idx),
        .i_wdata (ex.desc_wdata),
        .i_re    (req_acc),
        .i_raddr (in_idx),
        .o_rdata (pdr)
    );

    patu_page_ram u_base_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (exec_ld && ex.base_we),
        .i_waddr (r_idx),
        .i_wdata (ex.base_wdata),
        .i_re    (req_acc),
        .i_raddr (in_idx),
        .o_rdata (pbr)
    );

    patu_exec u_exec (
        .i_req_type   (r_req_type),
        .i_address    (r_address),
        .i_user_mode  (r_user_mode),
        .i_write_data (r_write_data),
        .i_pdr        (pdr),
        .i_pbr        (pbr),
        .i_enable     (r_mmu_enable),
        .i_abort      (r_abort),
        .o_res        (ex)
    );

    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.phys_addr   = r_out_phys;
    assign o_rsp.read_data   = r_out_rdata;
    assign o_rsp.fault       = r_out_fault;
    assign o_rsp.status_word = r_out_status;
endmodule

@@ rtl/patu_checker.sv @@
// Port-level checker for the translation unit and the bind that attaches it to the top.
// Depends on patu_pkg for the fault codes.
module patu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [patu_pkg::PHYS_W-1:0]  i_rsp_phys,
    input logic [patu_pkg::WORD_W-1:0]  i_rsp_rdata,
    input logic [2:0]                   i_rsp_fault,
    input logic [patu_pkg::WORD_W-1:0]  i_rsp_status
);
    import patu_pkg::*;

    // A stalled response keeps its address, fault code and status word.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_phys) &&
        $stable(i_rsp_fault) && $stable(i_rsp_status))
        else $error("response changed while stalled");

    // One request is in flight at a time, so no request is taken right after another.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    // An abort reports no address, relocation on and a status word with a cause bit.
    a_abort_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_fault == FLT_RDONLY || i_rsp_fault == FLT_NOACC ||
        i_rsp_fault == FLT_LEN) |-> i_rsp_phys == '0 && i_rsp_status[0] &&
        $countones(i_rsp_status[15:13]) == 1)
        else $error("abort response inconsistent");

    // A bus error returns nothing.
    a_bus_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_fault == FLT_BUS |-> i_rsp_rdata == '0 && i_rsp_phys == '0)
        else $error("bus error response carries data");

    // Reset leaves no response pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind paged_address_translation_unit_top patu_checker u_patu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_phys   (o_rsp.phys_addr),
    .i_rsp_rdata  (o_rsp.read_data),
    .i_rsp_fault  (o_rsp.fault),
    .i_rsp_status (o_rsp.status_word)
);
